// File: src/qsd_pkg.sv
// Shared types, codes and helpers for the QOI stream decoder.
`default_nettype none
package qsd_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int TABLE_AW      = $clog2(TABLE_ENTRIES);
    localparam int MAX_RUN       = 62;
    localparam int RUN_W         = $clog2(MAX_RUN + 1);
    localparam int OUT_DATA_W    = 112;

    // result kinds
    localparam logic [1:0] KIND_PIXEL     = 2'd0;
    localparam logic [1:0] KIND_HEADER    = 2'd1;
    localparam logic [1:0] KIND_BAD_MAGIC = 2'd2;
    localparam logic [1:0] KIND_BAD_CS    = 2'd3;

    // parser modes
    localparam logic [1:0] MODE_HEADER = 2'd0;
    localparam logic [1:0] MODE_PIXELS = 2'd1;
    localparam logic [1:0] MODE_IDLE   = 2'd2;

    // what the byte under execution produces
    localparam logic [1:0] CLS_NONE = 2'd0;
    localparam logic [1:0] CLS_ONE  = 2'd1;
    localparam logic [1:0] CLS_RUN  = 2'd2;

    // chunk tags
    localparam logic [7:0] TAG_RGB  = 8'hFE;
    localparam logic [7:0] TAG_RGBA = 8'hFF;
    localparam logic [1:0] OP_INDEX = 2'b00;
    localparam logic [1:0] OP_DIFF  = 2'b01;
    localparam logic [1:0] OP_LUMA  = 2'b10;

    localparam logic [31:0] PIXEL_START = 32'h0000_00FF;

    typedef struct packed {
        logic [1:0] cls;
        logic       out_free;
        logic       run_last;
    } t_status;

    typedef struct packed {
        logic accept;
        logic commit;
        logic run_step;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        last;
        logic        done;
        logic [31:0] width;
        logic [31:0] height;
        logic [7:0]  channels;
        logic        color_space;
    } t_result;

    function automatic logic [7:0] magic_byte(input logic [1:0] pos);
        case (pos)
            2'd0:    magic_byte = 8'h71;
            2'd1:    magic_byte = 8'h6F;
            2'd2:    magic_byte = 8'h69;
            default: magic_byte = 8'h66;
        endcase
    endfunction

    function automatic logic [TABLE_AW-1:0] pixel_hash(input logic [31:0] px);
        logic [TABLE_AW-1:0] r, g, b, a;
        r = px[24 +: TABLE_AW];
        g = px[16 +: TABLE_AW];
        b = px[8 +: TABLE_AW];
        a = px[0 +: TABLE_AW];
        pixel_hash = TABLE_AW'(r * 3) + TABLE_AW'(g * 5) + TABLE_AW'(b * 7)
                   + TABLE_AW'(a * 11);
    endfunction

endpackage
`default_nettype wire

// File: src/qoi_stream_decoder_top.sv
// QOI stream decoder: byte stream in, header, error and pixel results out.
//
// Input channel: one byte of a QOI file per request; tuser[0] marks the
// first header byte of a new file and restarts the parser.
// Output channel: one request per result. tuser holds the result kind,
// tlast marks the last result caused by one input byte.
// A single result goes from the byte register into the output register;
// the first pixel of a run passes through the run counter on the way.
// Throughput: the sequencer takes a byte, then executes it, and takes no
// new byte before that one is through; a run chunk of n pixels then comes
// out one pixel per cycle from the run counter while the output is free.
// The seen-pixel table is a 64-entry memory read when the byte is taken;
// a completed header clears its per-entry valid bits, so no clearing pass.
// Reset: the parser waits for a header, the output is empty.
// Stall: a result waits in the output register while tready is low; the
// sequencer holds the next result in execute or in the run state, and no
// further byte is taken meanwhile.
`default_nettype none
module qoi_stream_decoder_top (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  wire  [7:0]   i_s_axis_tdata,   // [7:0] data_byte
    input  wire  [0:0]   i_s_axis_tuser,   // [0] first_of_file
    output logic         o_m_axis_tvalid,
    input  wire          i_m_axis_tready,
    // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [32] image_done,
    // [64:33] width, [96:65] height, [104:97] channels, [105] color_space
    output logic [qsd_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic [1:0]   o_m_axis_tuser,   // [1:0] kind
    output logic         o_m_axis_tlast
);
    import qsd_pkg::*;

    t_cmd    cmd;
    t_status status;
    t_result res;

    qsd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    qsd_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (i_s_axis_tdata),
        .i_first     (i_s_axis_tuser[0]),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_result    (res)
    );

    assign o_m_axis_tdata = {6'd0, res.color_space, res.channels, res.height,
                             res.width, res.done, res.alpha, res.blue,
                             res.green, res.red};
    assign o_m_axis_tuser = res.kind;
    assign o_m_axis_tlast = res.last;

endmodule
`default_nettype wire

// File: src/qsd_ctrl.sv
// Sequencer for the QOI stream decoder: accept, execute, run burst.
`default_nettype none
module qsd_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  qsd_pkg::t_status i_status,
    output qsd_pkg::t_cmd    o_cmd
);
    import qsd_pkg::*;

    localparam logic [1:0] ST_ACCEPT = 2'd0;
    localparam logic [1:0] ST_EXEC   = 2'd1;
    localparam logic [1:0] ST_RUN    = 2'd2;

    logic [1:0] r_state, n_state;

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        case (r_state)
            ST_ACCEPT: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (i_status.cls)
                    CLS_ONE: begin
                        // hold until the output register can take the result
                        if (i_status.out_free) begin
                            o_cmd.commit = 1'b1;
                            n_state      = ST_ACCEPT;
                        end
                    end
                    CLS_RUN: begin
                        o_cmd.commit = 1'b1;
                        n_state      = ST_RUN;
                    end
                    default: begin
                        o_cmd.commit = 1'b1;
                        n_state      = ST_ACCEPT;
                    end
                endcase
            end
            ST_RUN: begin
                if (i_status.out_free) begin
                    o_cmd.run_step = 1'b1;
                    if (i_status.run_last) n_state = ST_ACCEPT;
                end
            end
            default: n_state = ST_ACCEPT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_ACCEPT;
        else          r_state <= n_state;
    end

endmodule
`default_nettype wire

// File: src/qsd_datapath.sv
// Parser state, seen-pixel table and result register of the QOI decoder.
`default_nettype none
module qsd_datapath (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire  [7:0]        i_byte,
    input  wire               i_first,
    input  qsd_pkg::t_cmd     i_cmd,
    output qsd_pkg::t_status  o_status,
    input  wire               i_out_ready,
    output logic              o_out_valid,
    output qsd_pkg::t_result  o_result
);
    import qsd_pkg::*;

    logic [31:0]         r_table [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_tvld;
    logic [31:0]         r_rd_px;
    logic                r_rd_vld;
    logic [7:0]          r_byte;
    logic                r_first;

    logic [1:0]  r_mode, n_mode;
    logic [3:0]  r_hpos, n_hpos;
    logic [31:0] r_w, n_w, r_h, n_h;
    logic [7:0]  r_ch, n_ch;
    logic [31:0] r_left, n_left;
    logic [31:0] r_prev, n_prev;
    logic [7:0]  r_tag, n_tag;
    logic [1:0]  r_cnt, n_cnt;
    logic [23:0] r_col, n_col;
    logic [RUN_W-1:0] r_run, n_run;
    logic        r_out_valid;
    t_result     r_out, res;

    logic [1:0]  cls;
    logic        wr_en, clr_tbl, emit1;
    logic [31:0] wr_px, px, prod;
    logic [1:0]  e_mode, cnt2;
    logic [3:0]  e_hpos;
    logic [31:0] e_w, e_h;
    logic [7:0]  e_ch, e_tag;
    logic [1:0]  e_cnt;
    logic [23:0] e_col, col2;
    logic [6:0]  rl;
    logic [7:0]  pr, pg, pb, pa, b, vg;
    logic        out_free;
    t_result     run_res;
    logic [31:0] run_left_n;

    assign out_free = !r_out_valid || i_out_ready;
    assign b  = r_byte;
    assign pr = r_prev[31:24];
    assign pg = r_prev[23:16];
    assign pb = r_prev[15:8];
    assign pa = r_prev[7:0];
    assign prod = r_w * r_h;
    assign vg = {2'b00, r_tag[5:0]};

    always_comb begin
        // restart clears parser fields before the byte is looked at
        e_mode = r_first ? MODE_HEADER : r_mode;
        e_hpos = r_first ? 4'd0 : r_hpos;
        e_w    = r_first ? 32'd0 : r_w;
        e_h    = r_first ? 32'd0 : r_h;
        e_ch   = r_first ? 8'd0 : r_ch;
        e_tag  = r_first ? 8'd0 : r_tag;
        e_cnt  = r_first ? 2'd0 : r_cnt;
        e_col  = r_first ? 24'd0 : r_col;

        n_mode = e_mode;  n_hpos = e_hpos;
        n_w = e_w;  n_h = e_h;  n_ch = e_ch;
        n_tag = e_tag;  n_cnt = e_cnt;  n_col = e_col;
        n_left = r_left;  n_prev = r_prev;
        n_run  = r_run;
        cls = CLS_NONE;  wr_en = 1'b0;  wr_px = r_prev;  clr_tbl = 1'b0;
        emit1 = 1'b0;  px = r_prev;  res = '0;
        col2 = {e_col[15:0], b};
        cnt2 = e_cnt + 2'd1;
        rl = {1'b0, b[5:0]} + 7'd1;
        if (rl > 7'(MAX_RUN)) rl = 7'(MAX_RUN);
        if (r_left < {25'd0, rl}) rl = r_left[6:0];

        if (e_mode == MODE_HEADER) begin
            if (e_hpos < 4'd4) begin
                if (b != magic_byte(e_hpos[1:0])) begin
                    n_mode   = MODE_IDLE;
                    cls      = CLS_ONE;
                    res.kind = KIND_BAD_MAGIC;
                    res.last = 1'b1;
                end else begin
                    n_hpos = e_hpos + 4'd1;
                end
            end else if (e_hpos < 4'd8) begin
                n_w = {e_w[23:0], b};  n_hpos = e_hpos + 4'd1;
            end else if (e_hpos < 4'd12) begin
                n_h = {e_h[23:0], b};  n_hpos = e_hpos + 4'd1;
            end else if (e_hpos == 4'd12) begin
                n_ch = b;  n_hpos = e_hpos + 4'd1;
            end else if (b > 8'd2) begin
                n_mode   = MODE_IDLE;
                cls      = CLS_ONE;
                res.kind = KIND_BAD_CS;
                res.last = 1'b1;
            end else begin
                // header position 13 is only reached without a restart
                n_left  = prod;
                n_prev  = PIXEL_START;
                clr_tbl = 1'b1;
                n_tag = '0;  n_cnt = '0;  n_col = '0;
                n_mode  = (prod == 32'd0) ? MODE_IDLE : MODE_PIXELS;
                cls     = CLS_ONE;
                res.kind        = KIND_HEADER;
                res.last        = 1'b1;
                res.done        = (prod == 32'd0);
                res.width       = r_w;
                res.height      = r_h;
                res.channels    = r_ch;
                res.color_space = (b != 8'd0);
            end
        end else if (e_mode == MODE_PIXELS && r_left != 32'd0) begin
            if (e_tag != 8'd0) begin
                if (e_tag[7:1] == TAG_RGB[7:1]) begin
                    if (e_cnt < 2'd3) begin
                        if (cnt2 < 2'd3 || e_tag == TAG_RGBA) begin
                            n_col = col2;  n_cnt = cnt2;
                        end else begin
                            px = {col2, pa};  emit1 = 1'b1;
                        end
                    end else begin
                        px = {e_col, b};  emit1 = 1'b1;
                    end
                end else begin
                    px = {pr + vg + {4'd0, b[7:4]} - 8'd40,
                          pg + vg - 8'd32,
                          pb + vg + {4'd0, b[3:0]} - 8'd40, pa};
                    emit1 = 1'b1;
                end
            end else if (b >= TAG_RGB || b[7:6] == OP_LUMA) begin
                n_tag = b;  n_cnt = '0;  n_col = '0;
            end else if (b[7:6] == OP_INDEX) begin
                px = r_rd_vld ? r_rd_px : 32'd0;  emit1 = 1'b1;
            end else if (b[7:6] == OP_DIFF) begin
                px = {pr + {6'd0, b[5:4]} - 8'd2, pg + {6'd0, b[3:2]} - 8'd2,
                      pb + {6'd0, b[1:0]} - 8'd2, pa};
                emit1 = 1'b1;
            end else begin
                cls   = CLS_RUN;
                wr_en = 1'b1;
                wr_px = r_prev;
                n_run = rl[RUN_W-1:0];
            end
            if (emit1) begin
                n_tag = '0;  n_cnt = '0;  n_col = '0;
                n_prev = px;
                wr_en  = 1'b1;
                wr_px  = px;
                n_left = r_left - 32'd1;
                if (n_left == 32'd0) n_mode = MODE_IDLE;
                cls       = CLS_ONE;
                res.kind  = KIND_PIXEL;
                res.red   = px[31:24];
                res.green = px[23:16];
                res.blue  = px[15:8];
                res.alpha = px[7:0];
                res.last  = 1'b1;
                res.done  = (n_left == 32'd0);
            end
        end
    end

    // one pixel of a run burst
    always_comb begin
        run_left_n    = r_left - 32'd1;
        run_res       = '0;
        run_res.kind  = KIND_PIXEL;
        run_res.red   = pr;
        run_res.green = pg;
        run_res.blue  = pb;
        run_res.alpha = pa;
        run_res.last  = (r_run == RUN_W'(1));
        run_res.done  = (run_left_n == 32'd0);
    end

    assign o_status.cls      = cls;
    assign o_status.out_free = out_free;
    assign o_status.run_last = (r_run == RUN_W'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_byte   <= i_byte;
            r_first  <= i_first;
            r_rd_px  <= r_table[i_byte[TABLE_AW-1:0]];
            r_rd_vld <= r_tvld[i_byte[TABLE_AW-1:0]];
        end
        if (i_cmd.commit && wr_en) r_table[pixel_hash(wr_px)] <= wr_px;
        if (i_cmd.commit && cls == CLS_ONE) r_out <= res;
        if (i_cmd.run_step) r_out <= run_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_HEADER;  r_hpos <= '0;
            r_w <= '0;  r_h <= '0;  r_ch <= '0;
            r_left <= '0;  r_prev <= PIXEL_START;
            r_tag <= '0;  r_cnt <= '0;  r_col <= '0;
            r_run <= '0;  r_tvld <= '0;  r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_mode <= n_mode;  r_hpos <= n_hpos;
                r_w <= n_w;  r_h <= n_h;  r_ch <= n_ch;
                r_left <= n_left;  r_prev <= n_prev;
                r_tag <= n_tag;  r_cnt <= n_cnt;  r_col <= n_col;
                r_run <= n_run;
                if (clr_tbl)    r_tvld <= '0;
                else if (wr_en) r_tvld[pixel_hash(wr_px)] <= 1'b1;
            end
            if (i_cmd.run_step) begin
                r_left <= run_left_n;
                r_run  <= r_run - RUN_W'(1);
                if (run_left_n == 32'd0) r_mode <= MODE_IDLE;
            end
            if ((i_cmd.commit && cls == CLS_ONE) || i_cmd.run_step)
                r_out_valid <= 1'b1;
            else if (i_out_ready)
                r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule
`default_nettype wire

// File: src/qsd_checker.sv
// Port-level checks for the QOI stream decoder, bound to the top level.
`default_nettype none
module qsd_checker (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         o_m_axis_tvalid,
    input wire         i_m_axis_tready,
    input wire [qsd_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input wire [1:0]   o_m_axis_tuser,
    input wire         o_m_axis_tlast
);
    import qsd_pkg::*;

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
        o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // header and error results end their byte's output
    a_nonpixel_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != KIND_PIXEL |-> o_m_axis_tlast)
        else $error("non-pixel result without tlast");

    a_nonpixel_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != KIND_PIXEL |->
        o_m_axis_tdata[31:0] == 32'd0)
        else $error("colour on non-pixel result");

    a_pixel_noheader: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == KIND_PIXEL |->
        o_m_axis_tdata[OUT_DATA_W-1:33] == '0)
        else $error("header fields on pixel result");

endmodule

bind qoi_stream_decoder_top qsd_checker u_qsd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
`default_nettype wire
